// ----- sv/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Queue depth, field widths, the key that orders the entries and the
// command that the top level broadcasts to the row of cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int ID_W        = 7;
    localparam int WORK_W      = 8;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int COUNT_OUT_W = 4;

    // Work codes that enqueue; any other value removes the ID.
    localparam logic [WORK_W-1:0] WORK_CLASS1 = 8'd1;
    localparam logic [WORK_W-1:0] WORK_CLASS3 = 8'd3;

    // Item kinds.
    localparam logic KIND_UPDATE = 1'b0;

    // Cell operations.
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_SHIFT  = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;

    // The class bit sits above the ID, so comparing keys as plain vectors
    // orders by class first and then by ascending ID.
    typedef struct packed {
        logic            cls;
        logic [ID_W-1:0] id;
    } t_key;

    typedef struct packed {
        logic [1:0] op;
        t_key       key;
        t_key       found_key;
    } t_cell_ctl;

endpackage

// ----- sv/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one key and, as the broadcast command says, keeps it, takes the key
// of its right neighbor to close a gap, or takes the new key or the key of
// its left neighbor to open one.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  t_key      i_left_key,
    input  logic      i_left_lt,
    input  t_key      i_right_key,
    output t_key      o_key,
    output logic      o_match,
    output logic      o_lt
);

    t_key r_key;
    t_key n_key;
    logic w_ge;

    always_comb begin
        o_match = i_valid && (r_key.id == i_ctl.key.id);
        w_ge    = i_valid && (r_key >= i_ctl.found_key);
        // The new key belongs at or before this slot.
        o_lt    = !i_valid || (i_ctl.key < r_key);
    end

    always_comb begin
        n_key = r_key;
        case (i_ctl.op)
            OP_SHIFT: begin
                if (w_ge) begin
                    n_key = i_right_key;
                end
            end
            OP_INSERT: begin
                if (o_lt) begin
                    n_key = i_left_lt ? i_left_key : i_ctl.key;
                end
            end
            default: n_key = r_key;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

// ----- sv/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded queue of member IDs in class and ID order
// A row of cells keeps the entries sorted; each item may remove and insert
// one ID and then reports count, head and the circular successor.
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer
//  item in   start, busy, i_kind, i_car_id, i_work   start high, busy low
//  result    o_done, o_accepted ... o_own_is_next    o_done high, one cycle
//  config    i_cfg_we, i_cfg_data                    i_cfg_we high
//
//  An item passes from its transfer to its result through the search, remove,
//  insert and report steps of the cell row, and busy is high throughout them.
//  The result strobe comes in the cycle after the report step, when busy is
//  already low again, so a new item is taken only once the previous one is
//  done, at the earliest in the same cycle as its result strobe. Reset empties
//  the queue and clears own_id; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_kind,
    input  logic [ID_W-1:0]         i_car_id,
    input  logic signed [WORK_W-1:0] i_work,
    input  logic                    i_cfg_we,
    input  logic [ID_W-1:0]         i_cfg_data,
    output logic                    o_done,
    output logic                    o_accepted,
    output logic [COUNT_OUT_W-1:0]  o_count,
    output logic                    o_head_valid,
    output logic [ID_W-1:0]         o_head_id,
    output logic                    o_next_valid,
    output logic [ID_W-1:0]         o_next_id,
    output logic                    o_own_is_next
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FIND   = 3'd1;
    localparam logic [2:0] ST_REMOVE = 3'd2;
    localparam logic [2:0] ST_INSERT = 3'd3;
    localparam logic [2:0] ST_REPORT = 3'd4;

    logic [2:0]      r_state;
    logic [2:0]      n_state;
    logic            r_kind;
    logic            r_enq;
    t_key            r_key;
    logic            r_found;
    logic            r_found_cls;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [ID_W-1:0] r_own;
    logic            r_accepted;

    logic            r_done;
    logic            r_out_acc;
    logic            r_head_valid;
    logic [ID_W-1:0] r_head_id;
    logic [ID_W-1:0] r_next_id;
    logic            r_own_next;

    t_cell_ctl              w_ctl;
    t_key                   w_key [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_match;
    logic [QUEUE_DEPTH-1:0] w_lt;
    logic                   w_any_match;
    logic                   w_match_cls;
    logic [ID_W-1:0]        w_succ;
    logic [ID_W-1:0]        w_next_id;
    logic                   w_do_remove;
    logic                   w_do_insert;
    logic                   w_enq_in;

    // ------------------------------------------------------------------
    // Row of cells
    // ------------------------------------------------------------------
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        assign w_valid[g] = (CNT_W'(g) < r_count);

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_valid     (w_valid[g]),
            .i_left_key  ((g == 0) ? w_ctl.key : w_key[(g == 0) ? 0 : g - 1]),
            .i_left_lt   ((g == 0) ? 1'b0 : w_lt[(g == 0) ? 0 : g - 1]),
            .i_right_key ((g == QUEUE_DEPTH - 1) ? w_key[g]
                                                 : w_key[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
            .o_key       (w_key[g]),
            .o_match     (w_match[g]),
            .o_lt        (w_lt[g])
        );
    end

    // ------------------------------------------------------------------
    // Reductions over the row: match flag, class of the match, successor
    // ------------------------------------------------------------------
    always_comb begin
        w_any_match = 1'b0;
        w_match_cls = 1'b0;
        w_succ      = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_any_match = w_any_match | w_match[i];
            w_match_cls = w_match_cls | (w_match[i] & w_key[i].cls);
            if (w_match[i]) begin
                // The last occupied slot wraps around to the head.
                if (i + 1 < QUEUE_DEPTH && w_valid[(i + 1 < QUEUE_DEPTH) ? i + 1 : i]) begin
                    w_succ = w_succ | w_key[(i + 1 < QUEUE_DEPTH) ? i + 1 : i].id;
                end else begin
                    w_succ = w_succ | w_key[0].id;
                end
            end
        end
        w_next_id = w_any_match ? w_succ : w_key[0].id;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign w_enq_in    = (i_work == WORK_CLASS1) || (i_work == WORK_CLASS3);
    assign w_do_remove = (r_kind == KIND_UPDATE) && r_found
                         && (!r_enq || (r_found_cls != r_key.cls));
    assign w_do_insert = (r_kind == KIND_UPDATE) && r_enq
                         && !(r_found && (r_found_cls == r_key.cls))
                         && (r_count < CNT_W'(QUEUE_DEPTH));

    always_comb begin
        w_ctl.key       = r_key;
        w_ctl.found_key = '{cls: r_found_cls, id: r_key.id};
        w_ctl.op        = OP_HOLD;
        n_state         = r_state;
        n_count         = r_count;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_FIND;
                end
            end
            ST_FIND: begin
                n_state = ST_REMOVE;
            end
            ST_REMOVE: begin
                if (w_do_remove) begin
                    w_ctl.op = OP_SHIFT;
                    n_count  = r_count - CNT_W'(1);
                end
                n_state = ST_INSERT;
            end
            ST_INSERT: begin
                if (w_do_insert) begin
                    w_ctl.op = OP_INSERT;
                    n_count  = r_count + CNT_W'(1);
                end
                n_state = ST_REPORT;
            end
            ST_REPORT: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_own   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= (r_state == ST_REPORT);
            if (i_cfg_we) begin
                r_own <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_kind     <= i_kind;
            r_enq      <= w_enq_in;
            r_key.cls  <= (i_work == WORK_CLASS3);
            r_key.id   <= i_car_id;
            r_accepted <= 1'b0;
        end
        if (r_state == ST_FIND) begin
            r_found     <= w_any_match;
            r_found_cls <= w_match_cls;
        end
        if (r_state == ST_INSERT) begin
            r_accepted <= w_do_insert;
        end
        if (r_state == ST_REPORT) begin
            r_out_acc    <= r_accepted;
            r_head_valid <= (r_count != '0);
            r_head_id    <= (r_count != '0) ? w_key[0].id : '0;
            r_next_id    <= (r_count != '0) ? w_next_id : '0;
            r_own_next   <= w_any_match && (w_succ == r_own);
        end
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_accepted    = r_out_acc;
    assign o_count       = COUNT_OUT_W'(r_count);
    assign o_head_valid  = r_head_valid;
    assign o_head_id     = r_head_id;
    assign o_next_valid  = r_head_valid;
    assign o_next_id     = r_next_id;
    assign o_own_is_next = r_own_next;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_ids_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("ID held by more than one occupied cell");

    a_done_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPORT) |=> o_done)
        else $error("result strobe missing after report step");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == ST_FIND))
        else $error("item transfer did not start the search");

    a_accept_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_accepted) |-> o_head_valid)
        else $error("accepted insert left the queue empty");

endmodule

// ----- test/sorted_priority_queue_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test: self-checking bench for the sorted priority queue
// A short table of directed items is followed by random update and query
// traffic over small pools of IDs, so that the queue fills, empties and
// reorders often. Each transfer is run through an in-bench model of the
// queue, and every result strobe is compared with the oldest expectation.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam logic KIND_QUERY  = 1'b1;
    localparam int   PHASES      = 6;
    localparam int   PHASE_ITEMS = 175;
    localparam int   POOL_SIZE   = 10;

    typedef struct packed {
        logic                   accepted;
        logic [COUNT_OUT_W-1:0] count;
        logic                   head_valid;
        logic [ID_W-1:0]        head_id;
        logic                   next_valid;
        logic [ID_W-1:0]        next_id;
        logic                   own_is_next;
    } t_status;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   id;
        logic [WORK_W-1:0] work;
        logic              typed;
        t_status           golden;
    } t_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     i_kind = 1'b0;
    logic [ID_W-1:0]          i_car_id = '0;
    logic signed [WORK_W-1:0] i_work = '0;
    logic                     i_cfg_we = 1'b0;
    logic [ID_W-1:0]          i_cfg_data = '0;
    logic                     o_done;
    logic                     o_accepted;
    logic [COUNT_OUT_W-1:0]   o_count;
    logic                     o_head_valid;
    logic [ID_W-1:0]          o_head_id;
    logic                     o_next_valid;
    logic [ID_W-1:0]          o_next_id;
    logic                     o_own_is_next;

    sorted_priority_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_car_id      (i_car_id),
        .i_work        (i_work),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_accepted    (o_accepted),
        .o_count       (o_count),
        .o_head_valid  (o_head_valid),
        .o_head_id     (o_head_id),
        .o_next_valid  (o_next_valid),
        .o_next_id     (o_next_id),
        .o_own_is_next (o_own_is_next)
    );

    // Queue contents as the bench believes them to be.
    t_key            queue_keys [QUEUE_DEPTH];
    int              queue_len = 0;
    logic [ID_W-1:0] own_id_model = '0;

    t_status pending_status [$];
    int      mismatches     = 0;
    int      items_sent     = 0;
    int      results_seen   = 0;
    int      full_refusals  = 0;
    int      own_next_hits  = 0;
    int      accepted_count = 0;

    int      insert_pct [PHASES] = '{70, 85, 50, 30, 70, 60};
    int      idle_pct   [PHASES] = '{25, 0, 40, 25, 15, 0};

    // Directed items. Only the rows whose outcome is obvious carry a typed result.
    t_row directed [0:22] = '{
        '{KIND_QUERY,  7'd0,   8'h00,       1'b1, '{1'b0, 4'd0, 1'b0, 7'd0, 1'b0, 7'd0, 1'b0}},
        '{KIND_UPDATE, 7'd127, 8'h80,       1'b1, '{1'b0, 4'd0, 1'b0, 7'd0, 1'b0, 7'd0, 1'b0}},
        '{KIND_UPDATE, 7'd0,   WORK_CLASS1, 1'b1, '{1'b1, 4'd1, 1'b1, 7'd0, 1'b1, 7'd0, 1'b1}},
        '{KIND_UPDATE, 7'd0,   WORK_CLASS1, 1'b0, '0},
        '{KIND_UPDATE, 7'd127, WORK_CLASS3, 1'b0, '0},
        '{KIND_UPDATE, 7'd5,   WORK_CLASS3, 1'b0, '0},
        '{KIND_UPDATE, 7'd127, WORK_CLASS1, 1'b0, '0},
        '{KIND_UPDATE, 7'd64,  WORK_CLASS1, 1'b0, '0},
        '{KIND_UPDATE, 7'd10,  WORK_CLASS3, 1'b0, '0},
        '{KIND_UPDATE, 7'd20,  WORK_CLASS3, 1'b0, '0},
        '{KIND_UPDATE, 7'd30,  WORK_CLASS1, 1'b0, '0},
        '{KIND_UPDATE, 7'd40,  WORK_CLASS1, 1'b0, '0},
        '{KIND_UPDATE, 7'd99,  WORK_CLASS3, 1'b0, '0},
        '{KIND_UPDATE, 7'd5,   WORK_CLASS1, 1'b0, '0},
        '{KIND_QUERY,  7'd77,  WORK_CLASS1, 1'b0, '0},
        '{KIND_QUERY,  7'd40,  8'h00,       1'b0, '0},
        '{KIND_QUERY,  7'd20,  8'h00,       1'b0, '0},
        '{KIND_UPDATE, 7'd64,  8'h7F,       1'b0, '0},
        '{KIND_UPDATE, 7'd0,   8'hFF,       1'b0, '0},
        '{KIND_UPDATE, 7'd30,  8'h80,       1'b0, '0},
        '{KIND_UPDATE, 7'd99,  8'h02,       1'b0, '0},
        '{KIND_UPDATE, 7'd77,  WORK_CLASS3, 1'b0, '0},
        '{KIND_QUERY,  7'd127, 8'h00,       1'b0, '0}
    };

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("Run timed out with %0d results outstanding.", pending_status.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Position of an ID in the queue, or the length when it is not queued.
    function automatic int locate_id(logic [ID_W-1:0] id);
        int i;
        for (i = 0; i < queue_len; i++)
            if (queue_keys[i].id == id)
                return i;
        return queue_len;
    endfunction

    function automatic void drop_entry(int pos);
        int i;
        if (pos >= queue_len)
            return;
        for (i = pos; i + 1 < queue_len; i++)
            queue_keys[i] = queue_keys[i + 1];
        queue_len--;
    endfunction

    function automatic t_status advance_queue(logic kind, logic [ID_W-1:0] id,
                                              logic [WORK_W-1:0] work);
        t_status st;
        t_key    key;
        int      pos;
        int      ins;
        int      i;
        int      nxt;
        st = '0;
        if (kind == KIND_UPDATE) begin
            if (work == WORK_CLASS1 || work == WORK_CLASS3) begin
                key.cls = (work == WORK_CLASS3);
                key.id  = id;
                pos     = locate_id(id);
                // Already queued with the same class leaves everything as it is.
                if (!(pos < queue_len && queue_keys[pos].cls == key.cls)) begin
                    drop_entry(pos);
                    if (queue_len >= QUEUE_DEPTH) begin
                        full_refusals++;
                    end else begin
                        ins = 0;
                        while (ins < queue_len && queue_keys[ins] < key)
                            ins++;
                        for (i = queue_len; i > ins; i--)
                            queue_keys[i] = queue_keys[i - 1];
                        queue_keys[ins] = key;
                        queue_len++;
                        st.accepted = 1'b1;
                        accepted_count++;
                    end
                end
            end else begin
                drop_entry(locate_id(id));
            end
        end
        st.count = COUNT_OUT_W'(queue_len);
        if (queue_len > 0) begin
            st.head_valid = 1'b1;
            st.head_id    = queue_keys[0].id;
            st.next_valid = 1'b1;
            pos = locate_id(id);
            if (pos < queue_len) begin
                nxt = (pos + 1 == queue_len) ? 0 : pos + 1;
                st.next_id     = queue_keys[nxt].id;
                st.own_is_next = (queue_keys[nxt].id == own_id_model);
                if (st.own_is_next)
                    own_next_hits++;
            end else begin
                st.next_id = queue_keys[0].id;
            end
        end
        return st;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("ERROR result %0d, %s: got %0d, want %0d", results_seen, field, got, want);
        mismatches++;
    endtask

    task automatic check_status(t_status got, t_status want);
        if (got.accepted !== want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
        if (got.count !== want.count)
            report_mismatch("count", got.count, want.count);
        if (got.head_valid !== want.head_valid)
            report_mismatch("head_valid", got.head_valid, want.head_valid);
        if (got.head_id !== want.head_id)
            report_mismatch("head_id", got.head_id, want.head_id);
        if (got.next_valid !== want.next_valid)
            report_mismatch("next_valid", got.next_valid, want.next_valid);
        if (got.next_id !== want.next_id)
            report_mismatch("next_id", got.next_id, want.next_id);
        if (got.own_is_next !== want.own_is_next)
            report_mismatch("own_is_next", got.own_is_next, want.own_is_next);
    endtask

    // Results cannot be held off, so every strobe is taken at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_status.size() == 0) begin
                $display("ERROR result %0d arrived with nothing outstanding", results_seen);
                mismatches++;
            end else begin
                check_status('{o_accepted, o_count, o_head_valid, o_head_id,
                               o_next_valid, o_next_id, o_own_is_next},
                             pending_status.pop_front());
            end
            results_seen++;
        end
    end

    // Holds the item on the ports until a transfer happens, then predicts it.
    task automatic send_item(t_row row);
        t_status st;
        start    <= 1'b1;
        i_kind   <= row.kind;
        i_car_id <= row.id;
        i_work   <= row.work;
        do @(posedge i_clk); while (busy !== 1'b0);
        st = advance_queue(row.kind, row.id, row.work);
        pending_status.push_back(row.typed ? row.golden : st);
        items_sent++;
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results();
        int n;
        start <= 1'b0;
        for (n = 0; n < 200 && pending_status.size() > 0; n++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_own_id(logic [ID_W-1:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        own_id_model = value;
    endtask

    initial begin
        logic [ID_W-1:0] id_pool [POOL_SIZE];
        t_row            row;
        int              ph;
        int              k;
        int              roll;
        logic [ID_W-1:0] own_value;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r]) begin
            send_item(directed[r]);
            if ($urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 17));
        end

        for (ph = 0; ph < PHASES; ph++) begin
            foreach (id_pool[p])
                id_pool[p] = ID_W'($urandom);
            // Alternate phases keep the extreme IDs in the pool.
            if (ph % 2 == 0) begin
                id_pool[0] = '0;
                id_pool[1] = '1;
            end
            case (ph)
                0: own_value = '1;
                1: own_value = '0;
                3: own_value = ID_W'($urandom);
                default: own_value = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            endcase
            write_own_id(own_value);

            for (k = 0; k < PHASE_ITEMS; k++) begin
                row  = '0;
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    // Noise: any ID and any work code.
                    row.kind = 1'($urandom_range(0, 1));
                    row.id   = ID_W'($urandom);
                    row.work = WORK_W'($urandom);
                end else begin
                    row.id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
                    if ($urandom_range(0, 99) < 15) begin
                        row.kind = KIND_QUERY;
                        row.work = WORK_W'($urandom);
                    end else if ($urandom_range(0, 99) < insert_pct[ph]) begin
                        row.kind = KIND_UPDATE;
                        row.work = $urandom_range(0, 1) ? WORK_CLASS3 : WORK_CLASS1;
                    end else begin
                        row.kind = KIND_UPDATE;
                        row.work = WORK_W'($urandom);
                    end
                end
                send_item(row);
                if ($urandom_range(0, 99) < idle_pct[ph])
                    idle_cycles($urandom_range(1, 17));
            end
        end

        drain_results();
        if (pending_status.size() != 0) begin
            $display("ERROR %0d expected results never arrived", pending_status.size());
            mismatches += pending_status.size();
        end

        $display("Sent %0d items over %0d own_id settings; %0d results compared.",
                 items_sent, PHASES + 1, results_seen);
        $display("Inserts taken %0d, refused on a full queue %0d, own_id next %0d times.",
                 accepted_count, full_refusals, own_next_hits);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
